/* hw/rtl/irc_tok_pkg.sv */
// Shared types and constants for the IRC line tokenizer.
// Holds character codes, role and status codes and the result record.
// No dependencies.
`default_nettype none

package irc_tok_pkg;

    localparam int unsigned MAX_LINE_DEFAULT   = 512;
    localparam int unsigned MAX_PARAMS_ALLOWED = 15;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ROLE_W   = 3;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned STATUS_W = 4;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    localparam logic [ROLE_W-1:0] ROLE_PREFIX = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_CMD    = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_MIDDLE = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_TRAIL  = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_END    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NULL         = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CMD       = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_PREFIX = 4'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_CMD    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY_PARAM  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_EMPTY_LAST   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG     = 4'd8;

    typedef struct packed {
        logic                hit;
        logic [BYTE_W-1:0]   data;
        logic [ROLE_W-1:0]   role;
        logic [IDX_W-1:0]    idx;
        logic [STATUS_W-1:0] status;
        logic                eom;
    } tok_res_t;

endpackage

`default_nettype wire

/* hw/rtl/irc_tok_fsm.sv */
// Per-byte line parser: holds the line state and decides each byte's result.
// Depends on irc_tok_pkg.
`default_nettype none

module irc_tok_fsm #(
    parameter int unsigned MAX_LINE = irc_tok_pkg::MAX_LINE_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step,
    input  wire logic [irc_tok_pkg::BYTE_W-1:0]   data,
    output irc_tok_pkg::tok_res_t                 res
);

    localparam int unsigned LEN_W = $clog2(MAX_LINE);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE - 1);
    localparam logic [irc_tok_pkg::IDX_W-1:0] PARAM_LIMIT =
        irc_tok_pkg::IDX_W'(irc_tok_pkg::MAX_PARAMS_ALLOWED);

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_PREFIX,
        PH_CMD,
        PH_GAP,
        PH_MIDDLE,
        PH_TRAIL_START,
        PH_TRAIL,
        PH_SKIP
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [irc_tok_pkg::STATUS_W-1:0]      err_reg, err_next;
    logic                                  null_reg, null_next;
    logic [irc_tok_pkg::IDX_W-1:0]         count_reg, count_next;
    logic [LEN_W-1:0]                      len_reg, len_next;
    logic                                  empty_reg, empty_next;

    logic [irc_tok_pkg::STATUS_W-1:0]      end_err;
    logic                                  good;

    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        null_next  = null_reg;
        count_next = count_reg;
        len_next   = len_reg;
        empty_next = empty_reg;
        res        = '0;
        end_err    = err_reg;
        good       = (err_reg == irc_tok_pkg::ST_OK) && !null_reg;

        if (data inside {irc_tok_pkg::CH_CR, irc_tok_pkg::CH_LF})
        begin
            if (len_reg != '0)
            begin
                if (good)
                begin
                    case (phase_reg)
                        PH_PREFIX:      end_err = irc_tok_pkg::ST_NO_CMD;
                        PH_CMD:         end_err = empty_reg ? irc_tok_pkg::ST_EMPTY_CMD
                                                            : irc_tok_pkg::ST_OK;
                        PH_GAP:         end_err = irc_tok_pkg::ST_EMPTY_PARAM;
                        PH_TRAIL_START: end_err = irc_tok_pkg::ST_EMPTY_LAST;
                        default:        end_err = irc_tok_pkg::ST_OK;
                    endcase
                end
                res.hit  = 1'b1;
                res.role = irc_tok_pkg::ROLE_END;
                res.eom  = 1'b1;
                if (err_reg == irc_tok_pkg::ST_TOO_LONG)
                    res.status = irc_tok_pkg::ST_TOO_LONG;
                else if (null_reg)
                    res.status = irc_tok_pkg::ST_NULL;
                else
                    res.status = end_err;
            end
            phase_next = PH_LINE_START;
            err_next   = irc_tok_pkg::ST_OK;
            null_next  = 1'b0;
            count_next = '0;
            len_next   = '0;
            empty_next = 1'b1;
        end
        else if (len_reg >= LEN_LIMIT)
        begin
            err_next   = irc_tok_pkg::ST_TOO_LONG;
            phase_next = PH_SKIP;
        end
        else
        begin
            len_next = len_reg + 1'b1;
            if (data == irc_tok_pkg::CH_NUL)
            begin
                null_next  = 1'b1;
                phase_next = PH_SKIP;
            end
            else if (good)
            begin
                res.data = data;
                case (phase_reg)
                    PH_LINE_START:
                    begin
                        if (data == irc_tok_pkg::CH_COLON)
                        begin
                            phase_next = PH_PREFIX;
                            empty_next = 1'b1;
                        end
                        else if (data == irc_tok_pkg::CH_SPACE)
                        begin
                            err_next   = irc_tok_pkg::ST_EMPTY_CMD;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_CMD;
                            empty_next = 1'b0;
                            res.hit    = 1'b1;
                            res.role   = irc_tok_pkg::ROLE_CMD;
                        end
                    end
                    PH_PREFIX:
                    begin
                        if (data == irc_tok_pkg::CH_SPACE)
                        begin
                            if (empty_reg)
                            begin
                                err_next   = irc_tok_pkg::ST_EMPTY_PREFIX;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_CMD;
                                empty_next = 1'b1;
                            end
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            res.hit    = 1'b1;
                            res.role   = irc_tok_pkg::ROLE_PREFIX;
                        end
                    end
                    PH_CMD:
                    begin
                        if (data == irc_tok_pkg::CH_SPACE)
                        begin
                            if (empty_reg)
                            begin
                                err_next   = irc_tok_pkg::ST_EMPTY_CMD;
                                phase_next = PH_SKIP;
                            end
                            else
                                phase_next = PH_GAP;
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            res.hit    = 1'b1;
                            res.role   = irc_tok_pkg::ROLE_CMD;
                        end
                    end
                    PH_GAP:
                    begin
                        if (data == irc_tok_pkg::CH_SPACE)
                        begin
                            err_next   = irc_tok_pkg::ST_EMPTY_PARAM;
                            phase_next = PH_SKIP;
                        end
                        else if (data == irc_tok_pkg::CH_COLON)
                            phase_next = PH_TRAIL_START;
                        else
                        begin
                            phase_next = PH_MIDDLE;
                            count_next = count_reg + 1'b1;
                            res.hit    = 1'b1;
                            res.role   = irc_tok_pkg::ROLE_MIDDLE;
                            res.idx    = count_reg;
                        end
                    end
                    PH_MIDDLE:
                    begin
                        if (data == irc_tok_pkg::CH_SPACE)
                        begin
                            if (count_reg >= PARAM_LIMIT)
                            begin
                                err_next   = irc_tok_pkg::ST_TOO_MANY;
                                phase_next = PH_SKIP;
                            end
                            else
                                phase_next = PH_GAP;
                        end
                        else
                        begin
                            res.hit  = 1'b1;
                            res.role = irc_tok_pkg::ROLE_MIDDLE;
                            res.idx  = count_reg - 1'b1;
                        end
                    end
                    PH_TRAIL_START:
                    begin
                        phase_next = PH_TRAIL;
                        count_next = count_reg + 1'b1;
                        res.hit    = 1'b1;
                        res.role   = irc_tok_pkg::ROLE_TRAIL;
                        res.idx    = count_reg;
                    end
                    PH_TRAIL:
                    begin
                        res.hit  = 1'b1;
                        res.role = irc_tok_pkg::ROLE_TRAIL;
                        res.idx  = count_reg - 1'b1;
                    end
                    default:
                    begin
                        res.hit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            err_reg   <= irc_tok_pkg::ST_OK;
            null_reg  <= 1'b0;
            count_reg <= '0;
            len_reg   <= '0;
            empty_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            null_reg  <= null_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            empty_reg <= empty_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/irc_line_tokenizer_unit.sv */
// Top level of the IRC line tokenizer: input register, parser, result register.
// Depends on irc_tok_pkg and irc_tok_fsm.
//
// Takes one raw byte a cycle from the link and gives at most one word per byte:
// a tagged content byte, or a status word when CR or LF closes a non-empty line.
// A byte is held in the input register and is decided on its way into the
// result register, which drives its word onto the output. One byte is taken
// every cycle while tok_stall is low; while a result word waits under tok_stall,
// the byte in the input register is held and rx_stall rises, whether or not
// that byte gives a word. Lines are limited to MAX_LINE-1 content bytes.
`default_nettype none

module irc_line_tokenizer_unit #(
    parameter int unsigned MAX_LINE = irc_tok_pkg::MAX_LINE_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               rx_valid,
    output logic                                    rx_stall,
    input  wire logic [irc_tok_pkg::BYTE_W-1:0]     in_byte,
    output logic                                    tok_valid,
    input  wire logic                               tok_stall,
    output logic [irc_tok_pkg::BYTE_W-1:0]          out_byte,
    output logic [irc_tok_pkg::ROLE_W-1:0]          role,
    output logic [irc_tok_pkg::IDX_W-1:0]           param_index,
    output logic [irc_tok_pkg::STATUS_W-1:0]        status,
    output logic                                    end_of_message
);

    logic                               rx_valid_reg;
    logic [irc_tok_pkg::BYTE_W-1:0]     rx_byte_reg;
    logic                               tok_valid_reg;
    irc_tok_pkg::tok_res_t              tok_reg;
    irc_tok_pkg::tok_res_t              res;
    logic                               out_free;
    logic                               advance;

    assign out_free = !tok_valid_reg || !tok_stall;
    assign advance  = rx_valid_reg && out_free;
    assign rx_stall = rx_valid_reg && !out_free;

    irc_tok_fsm #(
        .MAX_LINE (MAX_LINE)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .data  (rx_byte_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg  <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (!rx_stall)
                rx_valid_reg <= rx_valid;
            if (out_free)
                tok_valid_reg <= advance && res.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
            rx_byte_reg <= in_byte;
        if (advance && res.hit)
            tok_reg <= res;
    end

    assign tok_valid      = tok_valid_reg;
    assign out_byte       = tok_reg.data;
    assign role           = tok_reg.role;
    assign param_index    = tok_reg.idx;
    assign status         = tok_reg.status;
    assign end_of_message = tok_reg.eom;

endmodule

`default_nettype wire

/* hw/rtl/irc_tok_checker.sv */
// Port-level checks on the tokenizer's result words, bound to the top level.
// Depends on irc_tok_pkg and irc_line_tokenizer_unit.
`default_nettype none

module irc_tok_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               tok_valid,
    input  wire logic                               tok_stall,
    input  wire logic [irc_tok_pkg::BYTE_W-1:0]     out_byte,
    input  wire logic [irc_tok_pkg::ROLE_W-1:0]     role,
    input  wire logic [irc_tok_pkg::IDX_W-1:0]      param_index,
    input  wire logic [irc_tok_pkg::STATUS_W-1:0]   status,
    input  wire logic                               end_of_message
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(out_byte) && $stable(role)
            && $stable(status))
        else $error("stalled word changed");

    a_byte_word: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && role != irc_tok_pkg::ROLE_END |->
            status == irc_tok_pkg::ST_OK && !end_of_message)
        else $error("byte word carries status");

    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && role == irc_tok_pkg::ROLE_END |->
            end_of_message && out_byte == '0 && param_index == '0)
        else $error("malformed status word");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> role <= irc_tok_pkg::ROLE_END && status <= irc_tok_pkg::ST_TOO_LONG)
        else $error("code out of range");

    a_head_index: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (role == irc_tok_pkg::ROLE_PREFIX || role == irc_tok_pkg::ROLE_CMD)
            |-> param_index == '0)
        else $error("prefix or command byte with index");

endmodule

bind irc_line_tokenizer_unit irc_tok_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (tok_valid),
    .tok_stall      (tok_stall),
    .out_byte       (out_byte),
    .role           (role),
    .param_index    (param_index),
    .status         (status),
    .end_of_message (end_of_message)
);

`default_nettype wire
